[src/e2q_pkg.sv]
package e2q_pkg;

   // cordic configuration
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   // working widths
   localparam int ANG_W  = 16;
   localparam int CRD_W  = 34;
   localparam int TRIG_W = 22;
   localparam int PRD2_W = 44;
   localparam int PRD3_W = 66;
   localparam int SUM_W  = 68;
   localparam int Q_W    = 16;

   localparam logic signed [CRD_W-1:0] ANG_PI      = 34'sd3373259426;
   localparam logic signed [CRD_W-1:0] ANG_HALF_PI = 34'sd1686629713;
   localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [Q_W-1:0]   Q14_ONE     = 16'sd16384;

   // arctangent table in 2^-30 units
   function automatic logic signed [CRD_W-1:0] atan_entry(input int idx);
      logic signed [CRD_W-1:0] v;
      v = '0;
      unique case (idx)
         0:  v = 34'sd843314856;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043836;
         3:  v = 34'sd133525158;
         4:  v = 34'sd67021686;
         5:  v = 34'sd33543515;
         6:  v = 34'sd16775850;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194282;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } trig_type;

endpackage

[src/e2q_cordic.sv]
module e2q_cordic (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [e2q_pkg::ANG_W-1:0] angle,
   output e2q_pkg::trig_type                trig
);
   import e2q_pkg::*;

   localparam int N = RUN_STAGES;

   logic signed [CRD_W-1:0] x_ff [0:N];
   logic signed [CRD_W-1:0] y_ff [0:N];
   logic signed [CRD_W-1:0] z_ff [0:N];
   logic                    neg_ff [0:N];
   logic signed [CRD_W-1:0] z_in;
   logic signed [CRD_W-1:0] cx, cy;
   logic signed [CRD_W-1:0] rx, ry;
   trig_type                trig_ff;

   // fold the half angle into range
   always_comb begin
      z_in = {{(CRD_W-ANG_W-17){angle[ANG_W-1]}}, angle, 17'd0};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= GAIN_Q30;
         y_ff[0] <= '0;
         if (z_in > ANG_HALF_PI) begin
            z_ff[0] <= z_in - ANG_PI;
            neg_ff[0] <= 1'b1;
         end else if (z_in < -ANG_HALF_PI) begin
            z_ff[0] <= z_in + ANG_PI;
            neg_ff[0] <= 1'b1;
         end else begin
            z_ff[0] <= z_in;
            neg_ff[0] <= 1'b0;
         end
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][CRD_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
         end
      end
   end

   // quadrant fix and rounding to 2^-20
   always_comb begin
      cx = neg_ff[N] ? -x_ff[N] : x_ff[N];
      cy = neg_ff[N] ? -y_ff[N] : y_ff[N];
      rx = (cx + CRD_W'(512)) >>> 10;
      ry = (cy + CRD_W'(512)) >>> 10;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff.c <= rx[TRIG_W-1:0];
         trig_ff.s <= ry[TRIG_W-1:0];
      end
   end

   assign trig = trig_ff;

endmodule

[src/e2q_combine.sv]
module e2q_combine (
   input  logic                         clock,
   input  logic                         enable,
   input  e2q_pkg::trig_type            head,
   input  e2q_pkg::trig_type            att,
   input  e2q_pkg::trig_type            bank,
   output logic signed [e2q_pkg::Q_W-1:0] quat_w,
   output logic signed [e2q_pkg::Q_W-1:0] quat_x,
   output logic signed [e2q_pkg::Q_W-1:0] quat_y,
   output logic signed [e2q_pkg::Q_W-1:0] quat_z
);
   import e2q_pkg::*;

   // two-factor products of heading and attitude
   logic signed [PRD2_W-1:0] cc_ff, ss_ff, sc_ff, cs_ff;
   trig_type                 bank_ff;
   // three-factor products
   logic signed [PRD3_W-1:0] p_ff [0:7];
   logic signed [SUM_W-1:0]  sum_ff [0:3];
   logic signed [SUM_W-1:0]  sum_in [0:3];
   logic signed [Q_W-1:0]    q_ff [0:3];
   logic signed [Q_W-1:0]    q_in [0:3];
   logic signed [SUM_W-1:0]  r;

   always_ff @(posedge clock) begin
      if (enable) begin
         cc_ff   <= PRD2_W'(head.c * att.c);
         ss_ff   <= PRD2_W'(head.s * att.s);
         sc_ff   <= PRD2_W'(head.s * att.c);
         cs_ff   <= PRD2_W'(head.c * att.s);
         bank_ff <= bank;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff[0] <= PRD3_W'(cc_ff * bank_ff.c);
         p_ff[1] <= PRD3_W'(ss_ff * bank_ff.s);
         p_ff[2] <= PRD3_W'(ss_ff * bank_ff.c);
         p_ff[3] <= PRD3_W'(cc_ff * bank_ff.s);
         p_ff[4] <= PRD3_W'(sc_ff * bank_ff.c);
         p_ff[5] <= PRD3_W'(cs_ff * bank_ff.s);
         p_ff[6] <= PRD3_W'(cs_ff * bank_ff.c);
         p_ff[7] <= PRD3_W'(sc_ff * bank_ff.s);
      end
   end

   // sums of the product pairs
   always_comb begin
      sum_in[0] = SUM_W'(p_ff[0]) - SUM_W'(p_ff[1]);
      sum_in[1] = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]);
      sum_in[2] = SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]);
      sum_in[3] = SUM_W'(p_ff[6]) - SUM_W'(p_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) sum_ff[k] <= sum_in[k];
      end
   end

   // round to q1.14 and saturate
   always_comb begin
      r = '0;
      for (int k = 0; k < 4; k++) begin
         r = (sum_ff[k] + (SUM_W'(1) <<< 45)) >>> 46;
         if (r > SUM_W'(Q14_ONE))       q_in[k] = Q14_ONE;
         else if (r < -SUM_W'(Q14_ONE)) q_in[k] = -Q14_ONE;
         else                           q_in[k] = r[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) q_ff[k] <= q_in[k];
      end
   end

   assign quat_w = q_ff[0];
   assign quat_x = q_ff[1];
   assign quat_y = q_ff[2];
   assign quat_z = q_ff[3];

endmodule

[src/euler_to_quaternion_top.sv]
// euler angles to unit quaternion, heading-attitude-bank order
// request channel: req_valid/req_stall with bank, heading and attitude
// angles in signed q4.12 radians; a transfer happens when valid is high
// and stall is low
// response channel: rsp_valid/rsp_stall with quat_w/x/y/z in signed
// q1.14, each saturated to plus or minus one
// throughput: one item per cycle while no stalled result holds the pipeline
// the pipeline from request transfer to rsp_valid holds one fold stage,
// one register per cordic rotation, one rounding stage, two product
// stages, one sum stage and one output stage
// the whole pipeline advances together; when rsp_stall is high while a
// result is waiting, the pipeline holds and req_stall is raised, so
// nothing is lost or repeated; bubbles stay in place while stalled
// reset clears all valid bits; payload registers are not reset
module euler_to_quaternion_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [e2q_pkg::ANG_W-1:0] req_bank_angle,
   input  logic signed [e2q_pkg::ANG_W-1:0] req_heading_angle,
   input  logic signed [e2q_pkg::ANG_W-1:0] req_attitude_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [e2q_pkg::Q_W-1:0]   rsp_quat_w,
   output logic signed [e2q_pkg::Q_W-1:0]   rsp_quat_x,
   output logic signed [e2q_pkg::Q_W-1:0]   rsp_quat_y,
   output logic signed [e2q_pkg::Q_W-1:0]   rsp_quat_z
);
   import e2q_pkg::*;

   localparam int DEPTH = RUN_STAGES + 6;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             enable;
   trig_type         t_head, t_att, t_bank;

   // advance unless the output holds a stalled result
   assign enable    = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !enable;

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   e2q_cordic u_head (.clock, .enable, .angle(req_heading_angle),  .trig(t_head));
   e2q_cordic u_att  (.clock, .enable, .angle(req_attitude_angle), .trig(t_att));
   e2q_cordic u_bank (.clock, .enable, .angle(req_bank_angle),     .trig(t_bank));

   e2q_combine u_comb (
      .clock, .enable,
      .head(t_head), .att(t_att), .bank(t_bank),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y), .quat_z(rsp_quat_z)
   );

   assign rsp_valid = vld_ff[DEPTH-1];

endmodule

[src/e2q_checker.sv]
module e2q_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [e2q_pkg::Q_W-1:0] rsp_quat_w,
   input logic signed [e2q_pkg::Q_W-1:0] rsp_quat_x
);
   import e2q_pkg::*;

   // a stalled response stays valid and holds quat_w and quat_x
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x))
      else $error("stalled response changed");

   // input side stalls only behind a stalled response
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without cause");

   // quat_w stays within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= Q14_ONE && rsp_quat_w >= -Q14_ONE)
      else $error("quat_w out of range");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_quat_w, .rsp_quat_x
);

[tb/tb_euler_to_quaternion_top.sv]
module tb_euler_to_quaternion_top;
   timeunit 1ns;
   timeprecision 1ps;

   import e2q_pkg::*;

   localparam int LATENCY     = CORDIC_STAGES + 6;
   localparam int WATCH_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1050;

   typedef struct packed {
      logic signed [15:0] bank;
      logic signed [15:0] heading;
      logic signed [15:0] attitude;
   } angles_type;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_bank_angle = '0;
   logic signed [15:0] req_heading_angle = '0;
   logic signed [15:0] req_attitude_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   angles_type pending_angles[$];
   quat_type   expected_quats[$];
   int      errors = 0;
   int      sent_count = 0;
   int      got_count = 0;
   int      idle_cycles = 0;
   int      send_gap = 0;
   int      stall_gap = 0;
   bit      hold_sender = 1'b0;
   bit      stim_done = 1'b0;
   bit      req_taken = 1'b0;

   euler_to_quaternion_top dut (.*);

   // clock
   always #2 clock = ~clock;

   // arctangent of 2^-i in 2^-30 units
   function automatic longint atan_q30(input int i);
      longint tab[24] = '{843314856, 497837829, 263043836, 133525158,
         67021686, 33543515, 16775850, 8388437, 4194282, 2097149,
         1048575, 524287, 262143, 131071, 65535, 32767, 16383, 8191,
         4095, 2047, 1023, 511, 255, 127};
      return tab[i];
   endfunction

   // cosine and sine of half angle in 2^-20 units
   function automatic void half_trig(input logic signed [15:0] ang,
                                     output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 131072;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426;
         flip = 1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_q30(i);
         end else begin
            x += dx;
            y -= dy;
            z += atan_q30(i);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x + 512) >>> 10;
      s = (y + 512) >>> 10;
   endfunction

   // round a 2^-60 sum to q1.14 and clamp
   function automatic logic signed [15:0] round_q14(input logic signed [127:0] v);
      logic signed [127:0] q;
      q = (v + (128'sd1 <<< 45)) >>> 46;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q[15:0];
   endfunction

   function automatic logic signed [127:0] p3(input longint a, b, c);
      logic signed [127:0] r;
      r = 128'(a) * 128'(b);
      return r * 128'(c);
   endfunction

   function automatic quat_type angles_to_quat(input angles_type a);
      longint c1, s1, c2, s2, c3, s3;
      quat_type q;
      half_trig(a.heading, c1, s1);
      half_trig(a.attitude, c2, s2);
      half_trig(a.bank, c3, s3);
      q.w = round_q14(p3(c1, c2, c3) - p3(s1, s2, s3));
      q.x = round_q14(p3(s1, s2, c3) + p3(c1, c2, s3));
      q.y = round_q14(p3(s1, c2, c3) + p3(c1, s2, s3));
      q.z = round_q14(p3(c1, s2, c3) - p3(s1, c2, s3));
      return q;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic signed [15:0] rand_angle();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh7FFF - 16'($urandom_range(0, 3));
      if (r == 1) return 16'sh8000 + 16'($urandom_range(0, 3));
      if (r == 2) return 16'($urandom_range(0, 12868)) - 16'sd6434;
      return 16'($urandom);
   endfunction

   // stimulus
   initial begin
      logic signed [15:0] dir_vals[12];
      angles_type a;
      dir_vals = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
         16'sd6434, -16'sd6434, 16'sd6435, -16'sd6435, 16'sd12868,
         -16'sd12868, 16'sh5555};
      for (int i = 0; i < 12; i++) begin
         a.bank = dir_vals[i];
         a.heading = dir_vals[(i + 4) % 12];
         a.attitude = dir_vals[(i + 8) % 12];
         pending_angles.push_back(a);
      end
      pending_angles.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      pending_angles.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
      pending_angles.push_back('{16'sd6434, 16'sd6434, 16'sd6434});
      pending_angles.push_back('{16'sh5555, 16'shAAAA, 16'sh5555});
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         a.bank = rand_angle();
         a.heading = rand_angle();
         a.attitude = rand_angle();
         pending_angles.push_back(a);
      end
   end

   // reset
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // driver: request transfers, changes at falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            sent_count++;
            if (sent_count == 500) hold_sender = 1'b1;
         end
         if (hold_sender && expected_quats.size() == 0 && !req_taken)
            hold_sender = 1'b0;
         if (req_valid && !req_taken) begin
            // hold payload
         end else if (send_gap > 0 || hold_sender || pending_angles.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 1'b0;
            if (pending_angles.size() == 0 && !hold_sender) stim_done = 1'b1;
         end else begin
            angles_type a;
            a = pending_angles.pop_front();
            req_bank_angle <= a.bank;
            req_heading_angle <= a.heading;
            req_attitude_angle <= a.attitude;
            req_valid <= 1'b1;
            send_gap = (sent_count > 100 && sent_count < 200) ? 0 : pick_gap();
         end
         // result stall
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_gap = (sent_count > 300 && sent_count < 400) ? 0 : pick_gap();
         end
      end
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      req_taken = req_valid && !req_stall && !reset;
      if (!reset) begin
         idle_cycles++;
         if (req_taken) begin
            expected_quats.push_back(angles_to_quat({req_bank_angle,
               req_heading_angle, req_attitude_angle}));
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            got_count++;
            if (expected_quats.size() == 0) begin
               $error("unexpected result transfer");
               errors++;
            end else begin
               quat_type e;
               e = expected_quats.pop_front();
               if (rsp_quat_w !== e.w) begin
                  $error("quat_w expected %0d actual %0d", e.w, rsp_quat_w);
                  errors++;
               end
               if (rsp_quat_x !== e.x) begin
                  $error("quat_x expected %0d actual %0d", e.x, rsp_quat_x);
                  errors++;
               end
               if (rsp_quat_y !== e.y) begin
                  $error("quat_y expected %0d actual %0d", e.y, rsp_quat_y);
                  errors++;
               end
               if (rsp_quat_z !== e.z) begin
                  $error("quat_z expected %0d actual %0d", e.z, rsp_quat_z);
                  errors++;
               end
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      wait (stim_done && expected_quats.size() == 0 && !req_valid);
      repeat (LATENCY + 10) @(posedge clock);
      if (expected_quats.size() != 0) errors++;
      $display("covered %0d angle triples, %0d quaternions checked", sent_count, got_count);
      if (errors == 0) $display("tb_euler_to_quaternion_top: PASS");
      else $display("tb_euler_to_quaternion_top: FAIL");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCH_LIMIT);
      $display("watchdog expired with %0d results outstanding", expected_quats.size());
      $display("tb_euler_to_quaternion_top: FAIL");
      $finish;
   end

endmodule

[sim.f]
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_combine.sv
src/euler_to_quaternion_top.sv
src/e2q_checker.sv
tb/tb_euler_to_quaternion_top.sv
